// ===== sv/tgcp_pkg.sv =====
// Package for the glyph column packer: font ROM tables, glyph codes and
// the command/status types shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package tgcp_pkg;

    localparam int FONT_COLS = 11;

    typedef logic [5:0] glyph_idx_t;
    typedef logic [3:0] col_idx_t;
    typedef logic [3:0] glyph_w_t;
    typedef logic [FONT_COLS-1:0][7:0] glyph_cols_t;

    // Glyph indexes into the font.
    localparam glyph_idx_t GLYPH_BLANK  = 6'd0;
    localparam glyph_idx_t GLYPH_PERIOD = 6'd1;
    localparam glyph_idx_t GLYPH_DASH   = 6'd2;
    localparam glyph_idx_t GLYPH_COMMA  = 6'd3;
    localparam glyph_idx_t GLYPH_STAR   = 6'd4;
    localparam glyph_idx_t GLYPH_DOLLAR = 6'd5;
    localparam glyph_idx_t GLYPH_COLON  = 6'd6;
    localparam glyph_idx_t GLYPH_DIGIT0 = 6'd7;
    localparam glyph_idx_t GLYPH_DIGIT5 = 6'd12;
    localparam glyph_idx_t GLYPH_A      = 6'd17;
    localparam glyph_idx_t GLYPH_T      = 6'd35;
    localparam glyph_idx_t GLYPH_U      = 6'd36;
    localparam glyph_idx_t GLYPH_V      = 6'd37;
    localparam glyph_idx_t GLYPH_Y      = 6'd38;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;   // take the request on the input channel
        logic emit;     // load the next result into the output register
    } tgcp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic drop;     // presented character is dropped (page already full)
        logic last;     // the pending result is the last of its character
        logic out_free; // output register can take a result this cycle
    } tgcp_status_t;

    // Maps a character code to its glyph index.
    function automatic glyph_idx_t glyph_of(input logic [7:0] code);
        glyph_idx_t g;
        g = GLYPH_BLANK;
        if (code >= 8'h30 && code <= 8'h39) begin
            g = GLYPH_DIGIT0 + glyph_idx_t'(code - 8'h30);
        end else if (code >= 8'h41 && code <= 8'h52) begin
            // A through R are consecutive in the font.
            g = GLYPH_A + glyph_idx_t'(code - 8'h41);
        end else begin
            unique case (code)
                8'h53:   g = GLYPH_DIGIT5;   // S shares the glyph of 5
                8'h54:   g = GLYPH_T;
                8'h55:   g = GLYPH_U;
                8'h56:   g = GLYPH_V;
                8'h59:   g = GLYPH_Y;
                8'h2E:   g = GLYPH_PERIOD;
                8'h2D:   g = GLYPH_DASH;
                8'h2C:   g = GLYPH_COMMA;
                8'h2A:   g = GLYPH_STAR;
                8'h24:   g = GLYPH_DOLLAR;
                8'h3A:   g = GLYPH_COLON;
                default: g = GLYPH_BLANK;
            endcase
        end
        return g;
    endfunction

    // Native width of each glyph in columns.
    function automatic glyph_w_t glyph_width(input glyph_idx_t g);
        glyph_w_t w;
        unique case (g)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd8:                    w = 4'd3;
            6'd6:                                                  w = 4'd2;
            6'd7, 6'd9, 6'd12, 6'd19, 6'd20, 6'd21, 6'd22,
            6'd28, 6'd31, 6'd32:                                   w = 4'd4;
            6'd14, 6'd33:                                          w = 4'd6;
            6'd30:                                                 w = 4'd7;
            6'd37:                                                 w = 4'd11;
            default:                                               w = 4'd5;
        endcase
        return w;
    endfunction

    // Column patterns of each glyph, column 0 first, bit 0 is the top row.
    function automatic glyph_cols_t glyph_cols(input glyph_idx_t g);
        glyph_cols_t c;
        unique case (g)
            6'd1:  c = '{1: 8'h40, default: 8'h00};
            6'd2:  c = '{0: 8'h08, 1: 8'h08, 2: 8'h08, default: 8'h00};
            6'd3:  c = '{0: 8'h20, 1: 8'h60, default: 8'h00};
            6'd4:  c = '{0: 8'h02, 1: 8'h07, 2: 8'h02, default: 8'h00};
            6'd5:  c = '{0: 8'h4F, 1: 8'h49, 2: 8'hFF, 3: 8'h49, 4: 8'h79,
                         default: 8'h00};
            6'd6:  c = '{0: 8'h24, 1: 8'h24, default: 8'h00};
            6'd7:  c = '{0: 8'h3E, 1: 8'h41, 2: 8'h41, 3: 8'h3E, default: 8'h00};
            6'd8:  c = '{0: 8'h42, 1: 8'h7F, 2: 8'h40, default: 8'h00};
            6'd9:  c = '{0: 8'h79, 1: 8'h49, 2: 8'h49, 3: 8'h4F, default: 8'h00};
            6'd10: c = '{0: 8'h41, 1: 8'h49, 2: 8'h49, 3: 8'h55, 4: 8'h36,
                         default: 8'h00};
            6'd11: c = '{0: 8'h10, 1: 8'h18, 2: 8'h14, 3: 8'h12, 4: 8'h7F,
                         default: 8'h00};
            6'd12: c = '{0: 8'h4F, 1: 8'h49, 2: 8'h49, 3: 8'h79, default: 8'h00};
            6'd13: c = '{0: 8'h1C, 1: 8'h2A, 2: 8'h49, 3: 8'h29, 4: 8'h10,
                         default: 8'h00};
            6'd14: c = '{0: 8'h41, 1: 8'h21, 2: 8'h11, 3: 8'h09, 4: 8'h05,
                         5: 8'h03, default: 8'h00};
            6'd15: c = '{0: 8'h14, 1: 8'h2A, 2: 8'h49, 3: 8'h2A, 4: 8'h14,
                         default: 8'h00};
            6'd16: c = '{0: 8'h46, 1: 8'h2A, 2: 8'h19, 3: 8'h0A, 4: 8'h04,
                         default: 8'h00};
            6'd17: c = '{0: 8'h7C, 1: 8'h0A, 2: 8'h09, 3: 8'h0A, 4: 8'h7C,
                         default: 8'h00};
            6'd18: c = '{0: 8'h7F, 1: 8'h49, 2: 8'h49, 3: 8'h5D, 4: 8'h22,
                         default: 8'h00};
            6'd19: c = '{0: 8'h1C, 1: 8'h22, 2: 8'h41, 3: 8'h22, default: 8'h00};
            6'd20: c = '{0: 8'h7F, 1: 8'h41, 2: 8'h22, 3: 8'h1C, default: 8'h00};
            6'd21: c = '{0: 8'h7F, 1: 8'h49, 2: 8'h49, 3: 8'h49, default: 8'h00};
            6'd22: c = '{0: 8'h7F, 1: 8'h11, 2: 8'h11, 3: 8'h01, default: 8'h00};
            6'd23: c = '{0: 8'h1C, 1: 8'h22, 2: 8'h51, 3: 8'h51, 4: 8'h72,
                         default: 8'h00};
            6'd24: c = '{0: 8'h7F, 1: 8'h08, 2: 8'h08, 3: 8'h08, 4: 8'h7F,
                         default: 8'h00};
            6'd25: c = '{0: 8'h41, 1: 8'h41, 2: 8'h7F, 3: 8'h41, 4: 8'h41,
                         default: 8'h00};
            6'd26: c = '{0: 8'h21, 1: 8'h41, 2: 8'h21, 3: 8'h1F, 4: 8'h01,
                         default: 8'h00};
            6'd27: c = '{0: 8'h7F, 1: 8'h08, 2: 8'h14, 3: 8'h22, 4: 8'h41,
                         default: 8'h00};
            6'd28: c = '{0: 8'h7F, 1: 8'h40, 2: 8'h40, 3: 8'h40, default: 8'h00};
            6'd29: c = '{0: 8'h7F, 1: 8'h02, 2: 8'h04, 3: 8'h02, 4: 8'h7F,
                         default: 8'h00};
            6'd30: c = '{0: 8'h7F, 1: 8'h02, 2: 8'h04, 3: 8'h08, 4: 8'h10,
                         5: 8'h20, 6: 8'h7F, default: 8'h00};
            6'd31: c = '{0: 8'h3E, 1: 8'h41, 2: 8'h41, 3: 8'h3E, default: 8'h00};
            6'd32: c = '{0: 8'h7F, 1: 8'h09, 2: 8'h09, 3: 8'h06, default: 8'h00};
            6'd33: c = '{0: 8'h1C, 1: 8'h22, 2: 8'h41, 3: 8'h45, 4: 8'h22,
                         5: 8'h1D, default: 8'h00};
            6'd34: c = '{0: 8'h7F, 1: 8'h09, 2: 8'h19, 3: 8'h26, 4: 8'h40,
                         default: 8'h00};
            6'd35: c = '{0: 8'h01, 1: 8'h01, 2: 8'h7F, 3: 8'h01, 4: 8'h01,
                         default: 8'h00};
            6'd36: c = '{0: 8'h1F, 1: 8'h20, 2: 8'h40, 3: 8'h20, 4: 8'h1F,
                         default: 8'h00};
            6'd37: c = '{0: 8'h01, 1: 8'h02, 2: 8'h04, 3: 8'h08, 4: 8'h10,
                         5: 8'h20, 6: 8'h10, 7: 8'h08, 8: 8'h04, 9: 8'h02,
                         10: 8'h01};
            6'd38: c = '{0: 8'h01, 1: 8'h02, 2: 8'h7C, 3: 8'h02, 4: 8'h01,
                         default: 8'h00};
            default: c = '{default: 8'h00};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tgcp_ctrl.sv =====
// Controller of the glyph column packer: a two-state machine that takes a
// request and then steps the datapath through its results. Uses tgcp_pkg.
`default_nettype none

module tgcp_ctrl
    import tgcp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  tgcp_status_t      status,
    output tgcp_cmd_t         cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && !status.drop) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tgcp_dpath.sv =====
// Datapath of the glyph column packer: glyph lookup, room check, page
// position and full mark, column counter and output register. Uses tgcp_pkg.
`default_nettype none

module tgcp_dpath
    import tgcp_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH = 11
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  tgcp_cmd_t         cmd,
    output tgcp_status_t      status,
    input  wire logic [7:0]   page_bytes,
    input  wire logic [3:0]   char_gap,
    input  wire logic [7:0]   s_char_code,
    input  wire logic         s_new_page,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_column_pos,
    output logic [7:0]        m_column_bits,
    output logic [3:0]        m_glyph_width,
    output logic              m_last_of_char,
    output logic              m_page_full
);

    localparam logic [4:0] WIDTH_CAP = 5'(MAX_GLYPH_WIDTH);

    logic [7:0]  pos_reg;
    logic        full_reg;
    logic [7:0]  start_reg;
    glyph_idx_t  glyph_reg;
    glyph_w_t    width_reg;
    logic        fail_reg;
    col_idx_t    col_reg;
    logic        out_valid_reg;
    logic [7:0]  out_pos_reg;
    logic [7:0]  out_bits_reg;
    logic [3:0]  out_width_reg;
    logic        out_last_reg;
    logic        out_full_reg;

    logic [7:0]  eff_pos;
    logic        eff_full;
    glyph_idx_t  in_glyph;
    glyph_w_t    rom_width;
    glyph_w_t    in_width;
    logic        fits;
    logic [9:0]  adv_sum;
    logic [7:0]  adv_pos;
    glyph_cols_t cols;

    // A new page takes effect before the character is placed.
    assign eff_pos  = s_new_page ? 8'd1 : pos_reg;
    assign eff_full = s_new_page ? 1'b0 : full_reg;

    assign in_glyph  = glyph_of(s_char_code);
    assign rom_width = glyph_width(in_glyph);
    assign in_width  = ({1'b0, rom_width} > WIDTH_CAP) ? WIDTH_CAP[3:0] : rom_width;

    assign fits    = ({1'b0, eff_pos} + {5'd0, in_width}) <= {1'b0, page_bytes};
    assign adv_sum = {2'd0, eff_pos} + {6'd0, in_width} + {6'd0, char_gap};
    assign adv_pos = (adv_sum > 10'd255) ? 8'hFF : adv_sum[7:0];

    assign cols = glyph_cols(glyph_reg);

    assign status.drop     = eff_full;
    assign status.last     = fail_reg || (col_reg == width_reg - 4'd1);
    assign status.out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 8'd1;
            full_reg <= 1'b0;
        end else if (cmd.accept) begin
            full_reg <= eff_full || !fits;
            pos_reg  <= (!eff_full && fits) ? adv_pos : eff_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            start_reg <= eff_pos;
            glyph_reg <= in_glyph;
            width_reg <= in_width;
            fail_reg  <= !fits;
            col_reg   <= '0;
        end else if (cmd.emit) begin
            col_reg <= col_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_pos_reg   <= fail_reg ? start_reg : start_reg + {4'd0, col_reg};
            out_bits_reg  <= fail_reg ? 8'h00 : cols[col_reg];
            out_width_reg <= fail_reg ? 4'd0 : width_reg;
            out_last_reg  <= status.last;
            out_full_reg  <= fail_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_column_pos   = out_pos_reg;
    assign m_column_bits  = out_bits_reg;
    assign m_glyph_width  = out_width_reg;
    assign m_last_of_char = out_last_reg;
    assign m_page_full    = out_full_reg;

endmodule

`default_nettype wire

// ===== sv/text_to_glyph_column_packer_top.sv =====
// Glyph column packer top level: APB registers, controller and datapath.
// The controller takes a request in its idle state; in its emit state it loads
// one result per glyph column into the output register (a single one if the
// glyph does not fit), stalling while that register holds an unread result. A
// dropped character yields no result. Reset (aresetn, synchronous, low) sets the
// position to 1, clears the full mark and restores page_bytes 129, char_gap 4.
`default_nettype none

module text_to_glyph_column_packer_top
    import tgcp_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH = 11
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Character requests.
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_char_code,
    input  wire logic         s_new_page,
    // Column results.
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_column_pos,
    output logic [7:0]        m_column_bits,
    output logic [3:0]        m_glyph_width,
    output logic              m_last_of_char,
    output logic              m_page_full,
    // Configuration port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Register map: page_bytes at 0x0, char_gap at 0x4.
    localparam logic REG_PAGE_BYTES = 1'b0;
    localparam logic REG_CHAR_GAP   = 1'b1;

    logic [7:0]   page_bytes_reg;
    logic [3:0]   char_gap_reg;
    logic         cfg_write;
    tgcp_cmd_t    cmd;
    tgcp_status_t status;

    // The port never inserts wait states; a write lands in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_bytes_reg <= 8'd129;
            char_gap_reg   <= 4'd4;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_PAGE_BYTES: page_bytes_reg <= pwdata[7:0];
                REG_CHAR_GAP:   char_gap_reg   <= pwdata[3:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PAGE_BYTES: prdata = {24'd0, page_bytes_reg};
            REG_CHAR_GAP:   prdata = {28'd0, char_gap_reg};
            default:        prdata = '0;
        endcase
    end

    // The controller takes a request only when the previous character has
    // handed all of its results to the output register; the output register
    // itself lets the next request in while its last result still waits.
    tgcp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath looks up the glyph and checks room on the accept cycle, then
    // produces one column per cycle from the font ROM while the output is free.
    tgcp_dpath #(
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .page_bytes     (page_bytes_reg),
        .char_gap       (char_gap_reg),
        .s_char_code    (s_char_code),
        .s_new_page     (s_new_page),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_pos   (m_column_pos),
        .m_column_bits  (m_column_bits),
        .m_glyph_width  (m_glyph_width),
        .m_last_of_char (m_last_of_char),
        .m_page_full    (m_page_full)
    );

endmodule

`default_nettype wire
